FILE: design/dgsp_pkg.sv
// Shared types and constants for the dense-graph shortest-path block.
package dgsp_pkg;

	localparam int WEIGHT_W    = 16;
	localparam int DIST_W      = 20;
	localparam int FIELD_VW    = 4;
	localparam int MAX_RESULTS = 16;

	localparam logic [DIST_W-1:0] DIST_MAX = 20'hFFFFF;

	// Request kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_RUN  = 1'b1;

	typedef struct packed {
		logic                kind;
		logic [FIELD_VW-1:0] row;
		logic [FIELD_VW-1:0] col;
		logic [WEIGHT_W-1:0] weight;
		logic [FIELD_VW-1:0] source;
	} item_t;

	typedef struct packed {
		logic [FIELD_VW-1:0] vertex;
		logic [DIST_W-1:0]   distance;
		logic                reachable;
		logic                last;
	} result_t;

	// Shared add/compare unit: sum = sat(a + b), compared against c
	typedef struct packed {
		logic [DIST_W-1:0]   a;
		logic [WEIGHT_W-1:0] b;
		logic [DIST_W-1:0]   c;
	} alu_req_t;

	typedef struct packed {
		logic [DIST_W-1:0] sum;
		logic              lt;
		logic              eq;
	} alu_rsp_t;

endpackage

FILE: design/dgsp_alu.sv
// Shared saturating adder and magnitude comparator used by selection and relaxation.
module dgsp_alu (
	input  dgsp_pkg::alu_req_t req,
	output dgsp_pkg::alu_rsp_t rsp
);

	logic [dgsp_pkg::DIST_W:0]   sum_wide;
	logic [dgsp_pkg::DIST_W-1:0] sum_sat;

	// Add with one guard bit, clamp to the largest distance
	always_comb begin
		sum_wide = {1'b0, req.a} + (dgsp_pkg::DIST_W + 1)'(req.b);
		if (sum_wide > {1'b0, dgsp_pkg::DIST_MAX}) begin
			sum_sat = dgsp_pkg::DIST_MAX;
		end else begin
			sum_sat = sum_wide[dgsp_pkg::DIST_W-1:0];
		end
	end

	assign rsp.sum = sum_sat;
	assign rsp.lt  = sum_sat < req.c;
	assign rsp.eq  = sum_sat == req.c;

endmodule

FILE: design/dense_graph_shortest_paths_top.sv
// Single-source shortest paths over an adjacency-matrix graph, one shared add/compare unit.
//
// A load request writes one edge weight (zero removes the edge). A run request with a source
// below NUM_VERTICES is followed by NUM_VERTICES-1 rounds; each round scans all vertices to
// pick the next one and, when the picked vertex is reachable, scans its matrix row to relax
// neighbors. A run is paced by the single read port of the distance store and the one
// add/compare unit. Results come out in vertex order, at most 16, the final one marked last.
// The request channel is stalled for the whole run. After reset the block sweeps the matrix
// to zero, one entry per cycle, with the request channel stalled.
module dense_graph_shortest_paths_top #(
	parameter int NUM_VERTICES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  dgsp_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output dgsp_pkg::result_t result
);

	localparam int VW  = $clog2(NUM_VERTICES);
	localparam int MD  = NUM_VERTICES * NUM_VERTICES;
	localparam int AW  = $clog2(MD);
	localparam int CNT = (NUM_VERTICES < dgsp_pkg::MAX_RESULTS) ? NUM_VERTICES
		: dgsp_pkg::MAX_RESULTS;

	localparam logic [VW-1:0] LAST_V   = VW'(NUM_VERTICES - 1);
	localparam logic [VW-1:0] LAST_RND = VW'(NUM_VERTICES - 2);
	localparam logic [VW-1:0] LAST_OUT = VW'(CNT - 1);
	localparam logic [AW-1:0] LAST_A   = AW'(MD - 1);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PICK,
		ST_PICK_END,
		ST_SETTLE,
		ST_RELAX,
		ST_ROUND_END,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	state_t                        state_q;
	logic [AW-1:0]                 clr_q;
	logic [VW-1:0]                 idx_q;
	logic [VW-1:0]                 round_q;
	logic [VW-1:0]                 idx_s1;
	logic                          pick_s1;
	logic                          relax_s1;
	logic [NUM_VERTICES-1:0]       settled_q;
	logic [NUM_VERTICES-1:0]       reached_q;
	logic                          have_reached_q;
	logic [dgsp_pkg::DIST_W-1:0]   low_q;
	logic [VW-1:0]                 choice_q;
	logic                          res_valid_q;
	dgsp_pkg::result_t             res_q;

	// Memories
	logic [dgsp_pkg::WEIGHT_W-1:0] edge_mem [MD];
	logic [dgsp_pkg::WEIGHT_W-1:0] edge_rd_q;
	logic [dgsp_pkg::DIST_W-1:0]   dist_mem [NUM_VERTICES];
	logic [dgsp_pkg::DIST_W-1:0]   dist_rd_q;

	logic                          edge_we;
	logic [AW-1:0]                 edge_wa;
	logic [dgsp_pkg::WEIGHT_W-1:0] edge_wd;
	logic [AW-1:0]                 edge_ra;
	logic                          dist_we;
	logic [VW-1:0]                 dist_wa;
	logic [dgsp_pkg::DIST_W-1:0]   dist_wd;

	logic                          accept;
	logic                          load_ok;
	logic                          run_ok;
	logic                          relax_upd;
	logic                          pick_le;
	logic                          out_free;
	dgsp_pkg::alu_req_t            alu_req;
	dgsp_pkg::alu_rsp_t            alu_rsp;

	// Request decode
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign load_ok    = accept && (item.kind == dgsp_pkg::KIND_LOAD)
		&& (int'(item.row) < NUM_VERTICES) && (int'(item.col) < NUM_VERTICES);
	assign run_ok     = accept && (item.kind == dgsp_pkg::KIND_RUN)
		&& (int'(item.source) < NUM_VERTICES);

	// Shared unit: selection compares dist[v] to the running low, relaxation adds an edge
	always_comb begin
		if (relax_s1) begin
			alu_req = '{a: low_q, b: edge_rd_q, c: dist_rd_q};
		end else begin
			alu_req = '{a: dist_rd_q, b: '0, c: low_q};
		end
	end

	dgsp_alu u_dgsp_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign pick_le   = alu_rsp.lt || alu_rsp.eq;
	assign relax_upd = relax_s1 && !settled_q[idx_s1] && (edge_rd_q != '0)
		&& (!reached_q[idx_s1] || alu_rsp.lt);

	// Matrix port: sweep or load writes, row reads during relaxation
	always_comb begin
		edge_we = (state_q == ST_CLEAR) || load_ok;
		if (state_q == ST_CLEAR) begin
			edge_wa = clr_q;
			edge_wd = '0;
		end else begin
			edge_wa = AW'(item.row) * AW'(NUM_VERTICES) + AW'(item.col);
			edge_wd = item.weight;
		end
		edge_ra = AW'(choice_q) * AW'(NUM_VERTICES) + AW'(idx_q);
	end

	// Distance port: source seeds zero, relaxation writes new sums
	always_comb begin
		dist_we = run_ok || relax_upd;
		if (state_q == ST_IDLE) begin
			dist_wa = VW'(item.source);
			dist_wd = '0;
		end else begin
			dist_wa = idx_s1;
			dist_wd = alu_rsp.sum;
		end
	end

	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[edge_wa] <= edge_wd;
		end
		edge_rd_q <= edge_mem[edge_ra];
	end

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[dist_wa] <= dist_wd;
		end
		dist_rd_q <= dist_mem[idx_q];
	end

	assign out_free = !res_valid_q || !result_stall;

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			idx_q          <= '0;
			round_q        <= '0;
			idx_s1         <= '0;
			pick_s1        <= 1'b0;
			relax_s1       <= 1'b0;
			settled_q      <= '0;
			reached_q      <= '0;
			have_reached_q <= 1'b0;
			low_q          <= '0;
			choice_q       <= '0;
			res_valid_q    <= 1'b0;
			res_q          <= '0;
		end else begin
			pick_s1  <= (state_q == ST_PICK);
			relax_s1 <= (state_q == ST_RELAX);
			idx_s1   <= idx_q;

			// Result taken; the load state handles its own valid
			if (res_valid_q && !result_stall && (state_q != ST_EMIT_LD)) begin
				res_valid_q <= 1'b0;
			end

			// Selection step for the entry read last cycle
			if (pick_s1 && !settled_q[idx_s1]) begin
				if (reached_q[idx_s1]) begin
					if (!have_reached_q || pick_le) begin
						low_q          <= dist_rd_q;
						choice_q       <= idx_s1;
						have_reached_q <= 1'b1;
					end
				end else if (!have_reached_q) begin
					choice_q <= idx_s1;
				end
			end

			// Relaxation step for the entry read last cycle
			if (relax_upd) begin
				reached_q[idx_s1] <= 1'b1;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_A) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (run_ok) begin
						settled_q      <= '0;
						reached_q      <= {{(NUM_VERTICES-1){1'b0}}, 1'b1} << item.source;
						idx_q          <= '0;
						round_q        <= '0;
						have_reached_q <= 1'b0;
						low_q          <= '0;
						choice_q       <= '0;
						state_q        <= ST_PICK;
					end
				end
				ST_PICK: begin
					if (idx_q == LAST_V) begin
						idx_q   <= '0;
						state_q <= ST_PICK_END;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_PICK_END: begin
					state_q <= ST_SETTLE;
				end
				ST_SETTLE: begin
					settled_q[choice_q] <= 1'b1;
					state_q <= have_reached_q ? ST_RELAX : ST_ROUND_END;
				end
				ST_RELAX: begin
					if (idx_q == LAST_V) begin
						idx_q   <= '0;
						state_q <= ST_ROUND_END;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_ROUND_END: begin
					idx_q <= '0;
					if (round_q == LAST_RND) begin
						state_q <= ST_EMIT_RD;
					end else begin
						round_q        <= round_q + 1'b1;
						have_reached_q <= 1'b0;
						low_q          <= '0;
						choice_q       <= '0;
						state_q        <= ST_PICK;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					if (out_free) begin
						res_valid_q     <= 1'b1;
						res_q.vertex    <= dgsp_pkg::FIELD_VW'(idx_q);
						res_q.distance  <= reached_q[idx_q] ? dist_rd_q : '0;
						res_q.reachable <= reached_q[idx_q];
						res_q.last      <= (idx_q == LAST_OUT);
						if (idx_q == LAST_OUT) begin
							idx_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

FILE: design/dgsp_checker.sv
// Port-level checks for the shortest-path block, bound to the top level.
module dgsp_checker #(
	parameter int NUM_VERTICES = 16
) (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input dgsp_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_stall,
	input dgsp_pkg::result_t result
);

	localparam int CNT = (NUM_VERTICES < dgsp_pkg::MAX_RESULTS) ? NUM_VERTICES
		: dgsp_pkg::MAX_RESULTS;
	localparam logic [dgsp_pkg::FIELD_VW-1:0] LAST_OUT = dgsp_pkg::FIELD_VW'(CNT - 1);

	// A stalled request holds
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("stalled request changed");

	// A stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// The last marker sits on the final reported vertex only
	a_last_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.last == (result.vertex == LAST_OUT)))
		else $error("last marker on wrong vertex");

	// An unreachable vertex reports zero distance
	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.reachable |-> result.distance == '0)
		else $error("unreachable vertex with nonzero distance");

	// While a run is still reporting, no new request is taken
	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> item_stall)
		else $error("request taken while a run is still reporting");

endmodule

bind dense_graph_shortest_paths_top dgsp_checker #(
	.NUM_VERTICES (NUM_VERTICES)
) u_dgsp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

FILE: dv/dense_graph_shortest_paths_top_tb.sv
// Self-checking testbench for the dense-graph shortest-path block: edge loads, runs, distance check.
module dense_graph_shortest_paths_top_tb;

	localparam int NV          = 16;
	localparam int RESULTS_PER = (NV < dgsp_pkg::MAX_RESULTS) ? NV : dgsp_pkg::MAX_RESULTS;
	localparam int RANDOM_REQS = 330;
	localparam int TAIL_CYCLES = 4 * NV * NV;
	localparam int CYCLE_LIMIT = 600000;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		dgsp_pkg::item_t req;
		bit              drain;
		bit              quiet;
	} pending_t;

	logic              clk;
	logic              arst_n       = 1'b0;
	logic              item_valid   = 1'b0;
	logic              item_stall;
	dgsp_pkg::item_t   item         = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	dgsp_pkg::result_t result;

	// Golden copy of the matrix and the distances still owed by the block
	logic [dgsp_pkg::WEIGHT_W-1:0] adj_matrix [NV][NV];
	dgsp_pkg::result_t             expected_paths [$];
	pending_t                      pending [$];

	int  gap_left          = 0;
	int  stall_left        = 0;
	bit  quiet_mode        = 1'b0;
	int  requests_planned  = 0;
	int  requests_accepted = 0;
	int  runs_seen         = 0;
	int  loads_seen        = 0;
	int  distances_checked = 0;
	int  error_count       = 0;
	int  cycle_count       = 0;

	dense_graph_shortest_paths_top #(
		.NUM_VERTICES(NV)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short idle gaps, some long ones; none in quiet stretches
	function automatic int gap_length(input bit quiet);
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Weights: small ones give many ties, plus full range, max and edge removal
	function automatic logic [dgsp_pkg::WEIGHT_W-1:0] pick_weight();
		int r;
		int w;
		r = $urandom_range(0, 99);
		if (r < 55) w = $urandom_range(1, 20);
		else if (r < 78) w = $urandom_range(1, 65535);
		else if (r < 86) w = 65535;
		else w = 0;
		return w[dgsp_pkg::WEIGHT_W-1:0];
	endfunction

	function automatic dgsp_pkg::item_t make_load(input int r, input int c,
			input logic [dgsp_pkg::WEIGHT_W-1:0] w);
		dgsp_pkg::item_t req;
		int              s;
		s          = $urandom_range(0, 15);
		req.kind   = dgsp_pkg::KIND_LOAD;
		req.row    = r[dgsp_pkg::FIELD_VW-1:0];
		req.col    = c[dgsp_pkg::FIELD_VW-1:0];
		req.weight = w;
		req.source = s[dgsp_pkg::FIELD_VW-1:0];
		return req;
	endfunction

	function automatic dgsp_pkg::item_t make_run(input int s);
		dgsp_pkg::item_t req;
		int              r;
		int              c;
		int              w;
		r          = $urandom_range(0, 15);
		c          = $urandom_range(0, 15);
		w          = $urandom_range(0, 65535);
		req.kind   = dgsp_pkg::KIND_RUN;
		req.row    = r[dgsp_pkg::FIELD_VW-1:0];
		req.col    = c[dgsp_pkg::FIELD_VW-1:0];
		req.weight = w[dgsp_pkg::WEIGHT_W-1:0];
		req.source = s[dgsp_pkg::FIELD_VW-1:0];
		return req;
	endfunction

	task automatic queue_request(input dgsp_pkg::item_t req, input bit drain, input bit quiet);
		pending_t p;
		p.req   = req;
		p.drain = drain;
		p.quiet = quiet;
		pending.push_back(p);
		requests_planned++;
	endtask

	// Predict one accepted request: update the matrix or compute all distances
	function automatic void predict_request(input dgsp_pkg::item_t req);
		logic [dgsp_pkg::DIST_W-1:0] best_dist [NV];
		bit                          done [NV];
		bit                          seen [NV];
		logic [dgsp_pkg::DIST_W:0]   sum;
		logic [dgsp_pkg::DIST_W-1:0] low;
		bit                          have_seen;
		int                          u;
		dgsp_pkg::result_t           res;
		if (req.kind == dgsp_pkg::KIND_LOAD) begin
			if (req.row < NV && req.col < NV)
				adj_matrix[req.row][req.col] = req.weight;
			loads_seen++;
			return;
		end
		if (req.source >= NV) return;
		runs_seen++;
		for (int v = 0; v < NV; v++) begin
			best_dist[v] = '0;
			done[v]      = 1'b0;
			seen[v]      = 1'b0;
		end
		seen[req.source] = 1'b1;
		for (int rnd = 0; rnd < NV - 1; rnd++) begin
			// smallest reached distance, highest index on ties; else highest unsettled
			u         = 0;
			have_seen = 1'b0;
			low       = '0;
			for (int v = 0; v < NV; v++) begin
				if (done[v]) continue;
				if (seen[v]) begin
					if (!have_seen || best_dist[v] <= low) begin
						low       = best_dist[v];
						u         = v;
						have_seen = 1'b1;
					end
				end else if (!have_seen) begin
					u = v;
				end
			end
			done[u] = 1'b1;
			if (!seen[u]) continue;
			// relax unsettled neighbors
			for (int v = 0; v < NV; v++) begin
				if (done[v] || adj_matrix[u][v] == '0) continue;
				sum = {1'b0, best_dist[u]} + adj_matrix[u][v];
				if (sum > dgsp_pkg::DIST_MAX) sum = {1'b0, dgsp_pkg::DIST_MAX};
				if (!seen[v] || sum[dgsp_pkg::DIST_W-1:0] < best_dist[v]) begin
					best_dist[v] = sum[dgsp_pkg::DIST_W-1:0];
					seen[v]      = 1'b1;
				end
			end
		end
		for (int v = 0; v < RESULTS_PER; v++) begin
			res.vertex    = v[dgsp_pkg::FIELD_VW-1:0];
			res.distance  = seen[v] ? best_dist[v] : '0;
			res.reachable = seen[v];
			res.last      = (v == RESULTS_PER - 1);
			expected_paths.push_back(res);
		end
	endfunction

	// Request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				predict_request(item);
				requests_accepted++;
			end
			if (!(item_valid && item_stall)) begin
				if (gap_left > 0) begin
					item_valid <= 1'b0;
					gap_left   <= gap_left - 1;
				end else if (pending.size() > 0 &&
						(!pending[0].drain || expected_paths.size() == 0)) begin
					item       <= pending[0].req;
					item_valid <= 1'b1;
					quiet_mode <= pending[0].quiet;
					gap_left   <= gap_length(pending[0].quiet);
					void'(pending.pop_front());
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and random back-pressure
	always @(posedge clk) begin
		dgsp_pkg::result_t want;
		int                g;
		if (arst_n && result_valid === 1'b1 && !result_stall) begin
			if (expected_paths.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("ERROR: unexpected result vertex=%0d distance=%0d reachable=%0b last=%0b",
						result.vertex, result.distance, result.reachable, result.last);
			end else begin
				want = expected_paths.pop_front();
				distances_checked++;
				if (result.vertex !== want.vertex || result.distance !== want.distance ||
						result.reachable !== want.reachable || result.last !== want.last) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("ERROR: exp v=%0d d=%0d r=%0b l=%0b, got v=%0d d=%0d r=%0b l=%0b",
							want.vertex, want.distance, want.reachable, want.last,
							result.vertex, result.distance, result.reachable, result.last);
				end
			end
		end
		if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left   <= stall_left - 1;
		end else begin
			g = gap_length(quiet_mode);
			result_stall <= (g > 0);
			stall_left   <= (g > 0) ? g - 1 : 0;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ERROR: timeout, %0d of %0d requests accepted, %0d distances owed",
				requests_accepted, requests_planned, expected_paths.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Stimulus and end of test
	initial begin
		int  sel;
		int  n;
		int  r;
		int  w;
		bit  quiet;
		for (int i = 0; i < NV; i++)
			for (int j = 0; j < NV; j++)
				adj_matrix[i][j] = '0;

		// directed: empty graph, max-weight chain, self loop, ties, edge removal, cycle back
		queue_request(make_run(0), 1'b0, 1'b0);
		queue_request(make_run(15), 1'b0, 1'b0);
		queue_request(make_load(0, 15, 16'hFFFF), 1'b0, 1'b0);
		queue_request(make_load(15, 14, 16'hFFFF), 1'b0, 1'b0);
		queue_request(make_load(14, 13, 16'hFFFF), 1'b0, 1'b0);
		queue_request(make_load(13, 12, 16'hFFFF), 1'b0, 1'b0);
		queue_request(make_load(3, 3, 16'd7), 1'b0, 1'b1);
		queue_request(make_load(5, 6, 16'd1), 1'b0, 1'b1);
		queue_request(make_load(5, 7, 16'd1), 1'b0, 1'b1);
		queue_request(make_load(6, 9, 16'd2), 1'b0, 1'b1);
		queue_request(make_load(7, 9, 16'd2), 1'b0, 1'b1);
		queue_request(make_load(0, 5, 16'd3), 1'b0, 1'b0);
		queue_request(make_run(0), 1'b0, 1'b0);
		queue_request(make_run(5), 1'b0, 1'b0);
		queue_request(make_run(3), 1'b0, 1'b0);
		queue_request(make_load(0, 15, 16'd0), 1'b1, 1'b0);
		queue_request(make_run(0), 1'b0, 1'b0);
		queue_request(make_load(12, 0, 16'd1), 1'b0, 1'b0);
		queue_request(make_load(1, 2, 16'd0), 1'b0, 1'b0);
		queue_request(make_run(15), 1'b0, 1'b0);

		// random: mostly edge batches followed by a run, plus row scrubs and noise
		n = requests_planned;
		while (requests_planned < n + RANDOM_REQS) begin
			sel   = $urandom_range(0, 99);
			quiet = ($urandom_range(0, 7) == 0);
			if (sel < 70) begin
				r = $urandom_range(3, 14);
				for (int i = 0; i < r; i++)
					queue_request(make_load($urandom_range(0, 15), $urandom_range(0, 15),
						pick_weight()), (i == 0) && ($urandom_range(0, 9) == 0), quiet);
				queue_request(make_run($urandom_range(0, 15)), 1'b0, quiet);
				if ($urandom_range(0, 3) == 0)
					queue_request(make_run($urandom_range(0, 15)), 1'b0, quiet);
			end else if (sel < 82) begin
				r = $urandom_range(0, 15);
				for (int c = 0; c < NV; c++)
					queue_request(make_load(r, c, '0), 1'b0, quiet);
			end else if (sel < 92) begin
				queue_request(make_run($urandom_range(0, 15)), 1'b0, quiet);
			end else begin
				w = $urandom_range(0, 65535);
				queue_request(make_load($urandom_range(0, 15), $urandom_range(0, 15),
					w[dgsp_pkg::WEIGHT_W-1:0]), 1'b0, quiet);
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (requests_accepted < requests_planned) @(posedge clk);
		while (expected_paths.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d edge writes and %0d runs; %0d distances checked.",
			loads_seen, runs_seen, distances_checked);
		$display("Mismatches: %0d, distances still owed: %0d", error_count, expected_paths.size());
		if (error_count == 0 && expected_paths.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
